// ----- src/qdf_pkg.sv -----
`timescale 1ns / 1ps
package qdf_pkg;

  // Field and word widths
  localparam int LIMB_W     = 32;
  localparam int VEL_W      = 32;
  localparam int NODE_W     = 24;
  localparam int AXES       = 3;
  localparam int FORCE_W    = 64;
  localparam int REG_W      = 32;
  localparam int REG_FRAC   = 16;
  localparam int MUL_W      = 2 * LIMB_W;
  localparam int IN_DATA_W  = AXES * VEL_W + NODE_W;
  localparam int OUT_DATA_W = AXES * FORCE_W;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Square root unit
  localparam int RAD_W            = 2 * VEL_W;
  localparam int ROOT_W           = RAD_W / 2;
  localparam int REM_W            = ROOT_W + 3;
  localparam int SQRT_BITS_STAGE  = 2;
  localparam int SQRT_STAGES      = ROOT_W / SQRT_BITS_STAGE;

  // Product widths: K = four registers, KA = K * area (area < 2^9),
  // SK = speed * KA, P = |vel| * SK
  localparam int K_W       = 4 * REG_W;
  localparam int KA_W      = K_W + 9;
  localparam int KA_LIMBS  = (KA_W + LIMB_W - 1) / LIMB_W;
  localparam int SK_W      = KA_W + ROOT_W;
  localparam int SK_LIMBS  = (SK_W + LIMB_W - 1) / LIMB_W;
  localparam int P_W       = SK_W + VEL_W;
  localparam int P_SUM_W   = (SK_LIMBS + 1) * LIMB_W;

  localparam logic [REG_W-1:0]   REG_RESET     = 32'h0001_0000;
  localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_NEG_MAG = 64'h8000_0000_0000_0000;

  // Node classes
  localparam logic [NODE_W-1:0] NODE_PAIR_A  = 24'd10000;
  localparam logic [NODE_W-1:0] NODE_PAIR_B  = 24'd10001;
  localparam logic [NODE_W-1:0] NODE_BAND_LO = 24'd20000;
  localparam logic [NODE_W-1:0] NODE_BAND_HI = 24'd29999;

  typedef enum logic [1:0] {
    REG_DRAG_COEFF  = 2'd0,
    REG_AIR_DENSITY = 2'd1,
    REG_FORCE_SCALE = 2'd2,
    REG_INV_UNIT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    AREA_100 = 2'd0,
    AREA_200 = 2'd1,
    AREA_400 = 2'd2
  } area_t;

  // Per-word data that rides along the pipe
  typedef struct packed {
    logic [AXES-1:0][VEL_W-1:0] mag;
    logic [AXES-1:0]            neg;
    area_t                      area;
    logic                       last;
  } qdf_side_t;

endpackage

// ----- src/qdf_isqrt.sv -----
`timescale 1ns / 1ps
module qdf_isqrt
  import qdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_radicand,
  input  qdf_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output qdf_side_t         out_side
);

  logic [SQRT_STAGES-1:0] valid_r;
  logic [REM_W-1:0]       rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0]      root_r [SQRT_STAGES];
  logic [RAD_W-1:0]       rad_r  [SQRT_STAGES];
  qdf_side_t              side_r [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic              valid_in;
    qdf_side_t         side_in;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [RAD_W-1:0]  rad_nxt;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_head
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = in_radicand;
      assign valid_in = in_valid;
      assign side_in  = in_side;
    end else begin : g_body
      assign rem_in   = rem_r[s-1];
      assign root_in  = root_r[s-1];
      assign rad_in   = rad_r[s-1];
      assign valid_in = valid_r[s-1];
      assign side_in  = side_r[s-1];
    end

    // restoring square root, two result bits per stage
    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      rad_nxt  = rad_in;
      trial    = '0;
      for (int b = 0; b < SQRT_BITS_STAGE; b++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1 -: 2]};
        rad_nxt = rad_nxt << 2;
        trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        rad_r[s]  <= rad_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule

// ----- src/quadratic_drag_force.sv -----
`timescale 1ns / 1ps
// Quadratic drag force, one node per word.
//
// in_*  : stream of node words (velocity vector and node number, signed
//         fixed point with FRAC_BITS fraction bits); in_tlast marks the last
//         node of a set and comes back on out_tlast with that node's force.
// out_* : stream of force words, three saturated 64-bit components.
// cfg_* : APB-style register port, four 32-bit Q16.16 factors at byte
//         addresses 0x0, 0x4, 0x8, 0xC; pready is always high.
//
// Throughput: one word per cycle whenever in_tready is high. The depth is
// set by the 16-stage square root (two root bits per stage) plus the
// multiply/accumulate stages after it. The product of the four factors is
// formed by a short free-running pipe off the registers; after a write it
// settles well before any word reaches the stage that uses it.
//
// Reset (rst_n low, synchronous) empties the pipe and returns all factors
// to 1.0. When the receiver stalls, the pipe keeps going until the output
// register and a one-word skid register are both full; only then does
// in_tready drop. Nothing is lost or repeated.
module quadratic_drag_force
  import qdf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // node words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // vel_x, vel_y, vel_z, node_number
  input  logic                  in_tlast,   // last_node
  // force words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // force_x, force_y, force_z
  output logic                  out_tlast,  // final_force
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // right shift that drops the extra fraction bits and the factor one half
  localparam int SHIFT  = FRAC_BITS + 4 * REG_FRAC + 1;
  localparam int OVF_LO = SHIFT + FORCE_W;

  function automatic logic [MUL_W-1:0] umul32(input logic [LIMB_W-1:0] a,
                                              input logic [LIMB_W-1:0] b);
    return MUL_W'(a) * MUL_W'(b);
  endfunction

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic [REG_W-1:0] drag_coeff_r;
  logic [REG_W-1:0] air_density_r;
  logic [REG_W-1:0] force_scale_r;
  logic [REG_W-1:0] inv_unit_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_coeff_r  <= REG_RESET;
      air_density_r <= REG_RESET;
      force_scale_r <= REG_RESET;
      inv_unit_r    <= REG_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DRAG_COEFF:  drag_coeff_r  <= cfg_pwdata;
        REG_AIR_DENSITY: air_density_r <= cfg_pwdata;
        REG_FORCE_SCALE: force_scale_r <= cfg_pwdata;
        REG_INV_UNIT:    inv_unit_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DRAG_COEFF:  cfg_prdata = drag_coeff_r;
      REG_AIR_DENSITY: cfg_prdata = air_density_r;
      REG_FORCE_SCALE: cfg_prdata = force_scale_r;
      REG_INV_UNIT:    cfg_prdata = inv_unit_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Factor product K = coeff * density * scale * inv_unit, then K * 100.
  // Free-running; only depends on the registers.
  // ---------------------------------------------------------------------
  logic [MUL_W-1:0] k1_r, k2_r;
  logic [MUL_W-1:0] kll_r, klh_r, khl_r, khh_r;
  logic [K_W-1:0]   k_r;
  logic [KA_W-1:0]  ka100_r;

  always_ff @(posedge clk) begin
    k1_r    <= umul32(drag_coeff_r, air_density_r);
    k2_r    <= umul32(force_scale_r, inv_unit_r);
    kll_r   <= umul32(k1_r[LIMB_W-1:0],       k2_r[LIMB_W-1:0]);
    klh_r   <= umul32(k1_r[LIMB_W-1:0],       k2_r[MUL_W-1:LIMB_W]);
    khl_r   <= umul32(k1_r[MUL_W-1:LIMB_W],   k2_r[LIMB_W-1:0]);
    khh_r   <= umul32(k1_r[MUL_W-1:LIMB_W],   k2_r[MUL_W-1:LIMB_W]);
    k_r     <= {khh_r, kll_r}
               + (K_W'({1'b0, klh_r} + {1'b0, khl_r}) << LIMB_W);
    // 100 = 64 + 32 + 4
    ka100_r <= (KA_W'(k_r) << 6) + (KA_W'(k_r) << 5) + (KA_W'(k_r) << 2);
  end

  // ---------------------------------------------------------------------
  // Pipe control: advance unless the skid register holds a word
  // ---------------------------------------------------------------------
  logic en;
  logic out_valid_r, skid_valid_r;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // stage 1: magnitudes, area class
  logic      s1_valid_r;
  qdf_side_t s1_side_r, s1_side_nxt;
  logic [NODE_W-1:0] node;

  assign node = in_tdata[AXES*VEL_W +: NODE_W];

  always_comb begin
    s1_side_nxt = '0;
    for (int j = 0; j < AXES; j++) begin
      s1_side_nxt.neg[j] = in_tdata[j*VEL_W + VEL_W - 1];
      s1_side_nxt.mag[j] = s1_side_nxt.neg[j] ? (~in_tdata[j*VEL_W +: VEL_W] + VEL_W'(1))
                                              : in_tdata[j*VEL_W +: VEL_W];
    end
    if (node inside {NODE_PAIR_A, NODE_PAIR_B}) begin
      s1_side_nxt.area = AREA_100;
    end else if (node inside {[NODE_BAND_LO:NODE_BAND_HI]}) begin
      s1_side_nxt.area = AREA_200;
    end else begin
      s1_side_nxt.area = AREA_400;
    end
    s1_side_nxt.last = in_tlast;
  end

  // stage 2: squares
  logic             s2_valid_r;
  qdf_side_t        s2_side_r;
  logic [MUL_W-1:0] s2_sq_r [AXES];

  // stage 3: sum of squares (fits 64 bits: at most 3 * 2^62)
  logic             s3_valid_r;
  qdf_side_t        s3_side_r;
  logic [RAD_W-1:0] s3_sum_r;

  // square root
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  qdf_side_t         sq_side;

  qdf_isqrt u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (s3_valid_r),
    .in_radicand (s3_sum_r),
    .in_side     (s3_side_r),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_side    (sq_side)
  );

  // stage 4: speed * K * area, partial products
  logic [KA_W-1:0]            ka_sel;
  logic [KA_LIMBS*LIMB_W-1:0] ka_pad;
  logic                       s4_valid_r;
  qdf_side_t                  s4_side_r;
  logic [MUL_W-1:0]           s4_pp_r [KA_LIMBS];

  always_comb begin
    case (sq_side.area)
      AREA_100: ka_sel = ka100_r;
      AREA_200: ka_sel = ka100_r << 1;
      default:  ka_sel = ka100_r << 2;
    endcase
    ka_pad = (KA_LIMBS*LIMB_W)'(ka_sel);
  end

  // stage 5: sum partials (even limbs do not overlap, nor do odd ones)
  logic [3*MUL_W-1:0]          sk_sum;
  logic                        s5_valid_r;
  qdf_side_t                   s5_side_r;
  logic [SK_W-1:0]             s5_sk_r;
  logic [SK_LIMBS*LIMB_W-1:0]  sk_pad;

  assign sk_sum = {s4_pp_r[4], s4_pp_r[2], s4_pp_r[0]}
                + {LIMB_W'(0), s4_pp_r[3], s4_pp_r[1], LIMB_W'(0)};
  assign sk_pad = (SK_LIMBS*LIMB_W)'(s5_sk_r);

  // stage 6: |vel_j| * SK partial products, per axis
  logic             s6_valid_r;
  qdf_side_t        s6_side_r;
  logic [MUL_W-1:0] s6_pp_r [AXES][SK_LIMBS];

  // stage 7: full product per axis
  logic [P_SUM_W-1:0] p_sum [AXES];
  logic               s7_valid_r;
  qdf_side_t          s7_side_r;
  logic [P_W-1:0]     s7_p_r [AXES];

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      p_sum[j] = P_SUM_W'({s6_pp_r[j][4], s6_pp_r[j][2], s6_pp_r[j][0]})
               + {s6_pp_r[j][5], s6_pp_r[j][3], s6_pp_r[j][1], LIMB_W'(0)};
    end
  end

  // stage 8: scale down, saturate magnitude
  logic [FORCE_W-1:0] shifted [AXES];
  logic [FORCE_W-1:0] lim     [AXES];
  logic [FORCE_W-1:0] mag_sat [AXES];
  logic [AXES-1:0]    over;
  logic               s8_valid_r;
  qdf_side_t          s8_side_r;
  logic [FORCE_W-1:0] s8_mag_r [AXES];

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      shifted[j] = s7_p_r[j][SHIFT +: FORCE_W];
      over[j]    = |s7_p_r[j][P_W-1:OVF_LO];
      // negative velocity gives a positive force
      lim[j]     = s7_side_r.neg[j] ? FORCE_POS_MAX : FORCE_NEG_MAG;
      mag_sat[j] = (over[j] || (shifted[j] > lim[j])) ? lim[j] : shifted[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= sq_valid;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      s7_valid_r <= s6_valid_r;
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s2_side_r <= s1_side_r;
      for (int j = 0; j < AXES; j++) begin
        s2_sq_r[j] <= umul32(s1_side_r.mag[j], s1_side_r.mag[j]);
      end
      s3_side_r <= s2_side_r;
      s3_sum_r  <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
      s4_side_r <= sq_side;
      for (int i = 0; i < KA_LIMBS; i++) begin
        s4_pp_r[i] <= umul32(sq_root, ka_pad[i*LIMB_W +: LIMB_W]);
      end
      s5_side_r <= s4_side_r;
      s5_sk_r   <= sk_sum[SK_W-1:0];
      s6_side_r <= s5_side_r;
      for (int j = 0; j < AXES; j++) begin
        for (int i = 0; i < SK_LIMBS; i++) begin
          s6_pp_r[j][i] <= umul32(s5_side_r.mag[j], sk_pad[i*LIMB_W +: LIMB_W]);
        end
      end
      s7_side_r <= s6_side_r;
      for (int j = 0; j < AXES; j++) begin
        s7_p_r[j] <= p_sum[j][P_W-1:0];
      end
      s8_side_r <= s7_side_r;
      for (int j = 0; j < AXES; j++) begin
        s8_mag_r[j] <= mag_sat[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sign and output register with one-word skid
  // ---------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic                  out_last_r, skid_last_r;
  logic                  out_free;

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      out_data_nxt[j*FORCE_W +: FORCE_W] = s8_side_r.neg[j]
                                           ? s8_mag_r[j]
                                           : (~s8_mag_r[j] + FORCE_W'(1));
    end
  end

  assign out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (s8_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
      end
    end else if (s8_valid_r) begin
      if (out_free) begin
        out_data_r <= out_data_nxt;
        out_last_r <= s8_side_r.last;
      end else begin
        skid_data_r <= out_data_nxt;
        skid_last_r <= s8_side_r.last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- tb/quadratic_drag_force_test.sv -----
`timescale 1ns / 1ps
// Drag force block test: node words in, force words out, four factor registers.
module quadratic_drag_force_test;
  import qdf_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int HALF_PERIOD    = 6;
  localparam int SETTLE_CYCLES  = 40;       // pipe is 25 deep, plus margin
  localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall
  localparam int MAX_PRINTED    = 40;       // mismatch lines printed before going quiet
  localparam logic [REG_W-1:0] ONE = 32'h0001_0000;   // 1.0 in Q16.16

  // one node word as the sender sees it
  typedef struct {
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic [VEL_W-1:0]  vz;
    logic [NODE_W-1:0] node;
    logic              last;
  } node_word_t;

  // one force word as the receiver should see it
  typedef struct {
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fz;
    logic               last;
  } drag_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;   // vel_x, vel_y, vel_z, node_number
  logic                  in_tlast    = 1'b0; // last_node
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // force_x, force_y, force_z
  logic                  out_tlast;          // final_force
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // our copy of the factor registers, indexed by register
  logic [REG_W-1:0] factor_q [0:3];

  drag_t expected_forces [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off_req  = 1'b0;
  int  mismatches    = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  settings_used = 0;

  always #HALF_PERIOD clk = ~clk;

  quadratic_drag_force #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Force predictor
  // ---------------------------------------------------------------------------

  // floor(sqrt(x)), classic two-bits-per-step digit recurrence
  function automatic logic [31:0] root_floor(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  // One axis: exact product of speed, |v|, the four factors and the area,
  // then drop the fraction bits of the factors, the extra speed fraction
  // and the one half in one shift (truncation toward zero), saturate the
  // magnitude and put the sign opposite to the velocity.
  function automatic logic [FORCE_W-1:0] axis_force(logic [31:0] speed,
                                                     logic [VEL_W-1:0] raw,
                                                     logic [8:0] area);
    logic [255:0]       prod;
    logic [VEL_W-1:0]   mag;
    logic               neg;
    logic [FORCE_W-1:0] lim;
    logic [FORCE_W-1:0] res;
    neg = raw[VEL_W-1];
    mag = neg ? -raw : raw;          // -2^31 keeps its pattern, magnitude 2^31
    if (mag == 0 || speed == 0) return '0;
    prod = 256'(speed);
    prod *= 256'(mag);
    prod *= 256'(factor_q[REG_DRAG_COEFF]);
    prod *= 256'(factor_q[REG_AIR_DENSITY]);
    prod *= 256'(factor_q[REG_FORCE_SCALE]);
    prod *= 256'(factor_q[REG_INV_UNIT]);
    prod *= 256'(area);
    prod >>= FRAC_BITS + 4 * REG_FRAC + 1;
    lim = neg ? FORCE_POS_MAX : FORCE_NEG_MAG;
    res = prod[FORCE_W-1:0];
    if (prod[255:FORCE_W] != 0 || res > lim) res = lim;
    return neg ? res : -res;
  endfunction

  function automatic drag_t predict_drag(node_word_t w);
    logic [63:0] mx, my, mz;
    logic [31:0] speed;
    logic [8:0]  area;
    drag_t       f;
    mx = w.vx[VEL_W-1] ? {32'b0, -w.vx} : {32'b0, w.vx};
    my = w.vy[VEL_W-1] ? {32'b0, -w.vy} : {32'b0, w.vy};
    mz = w.vz[VEL_W-1] ? {32'b0, -w.vz} : {32'b0, w.vz};
    speed = root_floor(mx * mx + my * my + mz * mz);
    // frontal area class from the node number
    if (w.node == NODE_PAIR_A || w.node == NODE_PAIR_B)
      area = 9'd100;
    else if (w.node >= NODE_BAND_LO && w.node <= NODE_BAND_HI)
      area = 9'd200;
    else
      area = 9'd400;
    f.fx   = axis_force(speed, w.vx, area);
    f.fy   = axis_force(speed, w.vy, area);
    f.fz   = axis_force(speed, w.vz, area);
    f.last = w.last;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // keep the log short if the block is badly broken; every one still counts
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Every accepted force word is held against the oldest prediction.
  always @(posedge clk) begin : check_forces
    drag_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (expected_forces.size() == 0) begin
        report_mismatch("force word with nothing pending", out_tdata[63:0], '0);
      end else begin
        want = expected_forces.pop_front();
        if (out_tdata[63:0] !== want.fx)
          report_mismatch("force_x", out_tdata[63:0], want.fx);
        if (out_tdata[127:64] !== want.fy)
          report_mismatch("force_y", out_tdata[127:64], want.fy);
        if (out_tdata[191:128] !== want.fz)
          report_mismatch("force_z", out_tdata[191:128], want.fz);
        if (out_tlast !== want.last)
          report_mismatch("final_force", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random tready, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #4_800_000;
    $display("quadratic_drag_force_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic node_word_t node_word(logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                           logic [VEL_W-1:0] vz, logic [NODE_W-1:0] node,
                                           logic last);
    node_word_t w;
    w.vx = vx; w.vy = vy; w.vz = vz; w.node = node; w.last = last;
    return w;
  endfunction

  // Offer one word; the prediction is queued at the edge that takes it.
  // tvalid stays high on return so back-to-back words need no gap.
  task automatic send_node(input node_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w.node, w.vz, w.vy, w.vx};
    in_tlast  <= w.last;
    do @(posedge clk); while (!in_tready);
    expected_forces.push_back(predict_drag(w));
    words_sent++;
  endtask

  // Stop sending, let every pending force word come back, then let the pipe settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  // A read is checked against our copy.
  task automatic cfg_access(input reg_idx_t idx, input bit is_write,
                            input logic [REG_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (is_write)
      factor_q[idx] = data;
    else if (cfg_prdata !== factor_q[idx])
      report_mismatch($sformatf("readback of %s", idx.name()), 64'(cfg_prdata),
                      64'(factor_q[idx]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Only called with the block idle.
  task automatic program_factors(input logic [REG_W-1:0] coeff, input logic [REG_W-1:0] dens,
                                 input logic [REG_W-1:0] scale, input logic [REG_W-1:0] inv);
    cfg_access(REG_DRAG_COEFF,  1'b1, coeff);
    cfg_access(REG_AIR_DENSITY, 1'b1, dens);
    cfg_access(REG_FORCE_SCALE, 1'b1, scale);
    cfg_access(REG_INV_UNIT,    1'b1, inv);
    cfg_access(REG_DRAG_COEFF,  1'b0, '0);
    cfg_access(REG_AIR_DENSITY, 1'b0, '0);
    cfg_access(REG_FORCE_SCALE, 1'b0, '0);
    cfg_access(REG_INV_UNIT,    1'b0, '0);
    settings_used++;
  endtask

  // Velocity mix: zeros, full range, small and medium magnitudes, extremes.
  function automatic logic [VEL_W-1:0] rand_vel();
    logic [VEL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1, 2, 3: v = $urandom;
      4, 5, 6: v = $urandom_range(0, 32'h0010_0000);    // up to 16.0
      7:       v = $urandom_range(0, 32'h0100_0000);
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Node mix: the pair, the band, their edges, anything else.
  function automatic logic [NODE_W-1:0] rand_node();
    logic [NODE_W-1:0] n;
    case ($urandom_range(0, 7))
      0: n = NODE_PAIR_A;
      1: n = NODE_PAIR_B;
      2: n = NODE_W'($urandom_range(NODE_BAND_LO, NODE_BAND_HI));
      3: begin
        case ($urandom_range(0, 3))
          0:       n = NODE_PAIR_A - NODE_W'(1);
          1:       n = NODE_PAIR_B + NODE_W'(1);
          2:       n = NODE_BAND_LO - NODE_W'(1);
          default: n = NODE_BAND_HI + NODE_W'(1);
        endcase
      end
      default: n = NODE_W'($urandom_range(0, 24'hFF_FFFF));
    endcase
    return n;
  endfunction

  function automatic node_word_t rand_node_word();
    return node_word(rand_vel(), rand_vel(), rand_vel(), rand_node(),
                     $urandom_range(0, 7) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Factors must read back as 1.0 out of reset.
  task automatic test_reset_factors();
    cfg_access(REG_DRAG_COEFF,  1'b0, '0);
    cfg_access(REG_AIR_DENSITY, 1'b0, '0);
    cfg_access(REG_FORCE_SCALE, 1'b0, '0);
    cfg_access(REG_INV_UNIT,    1'b0, '0);
  endtask

  // Hand-picked words at default factors: zero speed, zero components,
  // every area class and its edges, field extremes, tiny forces that truncate.
  task automatic test_directed_nodes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_node(node_word('0, '0, '0, 24'd0, 1'b0));
    send_node(node_word(ONE, '0, '0, NODE_PAIR_A, 1'b0));
    send_node(node_word('0, -ONE, '0, NODE_PAIR_B, 1'b0));
    send_node(node_word('0, '0, 32'h0002_8000, NODE_PAIR_A - NODE_W'(1), 1'b0));
    send_node(node_word(ONE, 2 * ONE, 3 * ONE, NODE_PAIR_B + NODE_W'(1), 1'b0));
    send_node(node_word(-3 * ONE, 4 * ONE, '0, NODE_BAND_LO - NODE_W'(1), 1'b0));
    send_node(node_word(ONE, ONE, ONE, NODE_BAND_LO, 1'b0));
    send_node(node_word(-ONE, -ONE, -ONE, NODE_BAND_HI, 1'b0));
    send_node(node_word(ONE, -ONE, ONE, NODE_BAND_HI + NODE_W'(1), 1'b0));
    send_node(node_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0));
    send_node(node_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd25000, 1'b0));
    send_node(node_word(32'h7FFF_FFFF, 32'h8000_0000, '0, NODE_PAIR_A, 1'b0));
    send_node(node_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 24'd0, 1'b1));
    send_node(node_word(32'h7FFF_FFFF, '0, '0, NODE_BAND_LO, 1'b1));
    send_node(node_word(32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A988, 24'hAB_CDEF, 1'b0));
    send_node(node_word(32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 24'h55_5555, 1'b1));
    wait_idle();
  endtask

  // Factors at zero, at full scale (forces saturate both ways) and lopsided.
  task automatic test_factor_extremes();
    program_factors('0, '0, '0, '0);
    send_node(node_word(32'h7FFF_FFFF, 32'h8000_0000, ONE, 24'd0, 1'b0));
    send_node(node_word(-ONE, ONE, '0, NODE_BAND_LO, 1'b1));
    wait_idle();

    program_factors('1, '1, '1, '1);
    send_node(node_word(32'h7FFF_FFFF, 32'h8000_0000, '0, 24'd0, 1'b0));
    send_node(node_word(ONE, -ONE, '0, NODE_PAIR_A, 1'b0));
    // smallest speed: large but below the limit
    send_node(node_word(32'h0000_0001, '0, '0, NODE_PAIR_B, 1'b0));
    send_node(node_word('0, '0, 32'hFFFF_FFFF, NODE_BAND_HI, 1'b1));
    wait_idle();

    program_factors('1, 32'h0000_0001, ONE, 32'h0000_8000);
    send_node(node_word(32'h0123_4567, -32'h0076_5432, 32'h0001_0000, 24'd12345, 1'b0));
    send_node(node_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'd0, 1'b1));
    wait_idle();
  endtask

  // A run of random words under one idling pattern and one factor setting.
  task automatic test_random_stream(input int s_idle, input int r_idle, input int count,
                                    input bit wild_factors);
    if (wild_factors)
      program_factors($urandom, $urandom, $urandom, $urandom);
    else
      program_factors($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                      $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000));
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_node(rand_node_word());
    wait_idle();
  endtask

  // Receiver stops for a long stretch while the sender keeps offering words;
  // the pipe and skid register fill and in_tready has to drop.
  task automatic test_backpressure();
    program_factors(ONE, ONE, ONE, ONE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (110) send_node(rand_node_word());
    wait_idle();
  endtask

  initial begin : main
    factor_q[REG_DRAG_COEFF]  = REG_RESET;
    factor_q[REG_AIR_DENSITY] = REG_RESET;
    factor_q[REG_FORCE_SCALE] = REG_RESET;
    factor_q[REG_INV_UNIT]    = REG_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_factors();
    test_directed_nodes();
    test_factor_extremes();
    test_random_stream(27, 60, 650, 1'b0);
    test_random_stream(60, 27, 650, 1'b1);
    test_random_stream(0, 0, 520, 1'b0);
    test_backpressure();

    // anything still queued here is a word the block dropped
    if (expected_forces.size() != 0)
      report_mismatch("force words never returned", 64'(expected_forces.size()), '0);

    $display("Sent %0d node words and checked %0d force words over %0d factor settings,",
             words_sent, words_checked, settings_used);
    $display("with random gaps on both sides and a %0d-cycle output stall.", HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("quadratic_drag_force_test passed");
    end else begin
      $display("quadratic_drag_force_test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/qdf_pkg.sv
src/qdf_isqrt.sv
src/quadratic_drag_force.sv
tb/quadratic_drag_force_test.sv
